@@ hdl/cbad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_pkg - CAN bit-rate search shared definitions
// Field widths, operation and status codes, register indexes, item and
// result types, and the speed table scan functions.
// ----------------------------------------------------------------------------
package cbad_pkg;

  localparam int NUM_SPEEDS = 9;
  localparam int MASK_W     = 9;
  localparam int IDX_W      = 4;
  localparam int SLOTS      = 2 ** IDX_W;
  localparam int CNT_W      = 8;
  localparam int TICK_W     = 16;
  localparam int STAT_W     = 3;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TBL_SPEEDS = (NUM_SPEEDS < MASK_W) ? NUM_SPEEDS : MASK_W;

  localparam logic [OP_W-1:0] OP_START  = 3'd0;
  localparam logic [OP_W-1:0] OP_FRAME  = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
  localparam logic [OP_W-1:0] OP_STATUS = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd4;

  localparam logic [STAT_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STAT_W-1:0] ST_SEARCH = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLOSED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFERRED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;

  localparam logic [MASK_W-1:0] MASK_RST     = 9'h1FF;
  localparam logic [IDX_W-1:0]  PREF_RST     = 4'd0;
  localparam logic [CNT_W-1:0]  ERR_LIM_RST  = 8'd10;
  localparam logic [CNT_W-1:0]  HIT_LIM_RST  = 8'd10;
  localparam logic [TICK_W-1:0] TIMEOUT_RST  = 16'd3000;
  localparam logic [CNT_W-1:0]  CNT_MAX      = 8'hFF;
  localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [MASK_W-1:0] enable_mask;
    logic [IDX_W-1:0]  preferred_speed;
    logic [CNT_W-1:0]  error_limit;
    logic [CNT_W-1:0]  hit_limit;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic            frame_error;
    logic            frame_extended;
    logic            device_open;
    logic            bus_off;
  } item_t;

  typedef struct packed {
    logic              restore_normal;
    logic              request_reset;
    logic              apply_speed;
    logic              saw_extended;
    logic              saw_standard;
    logic [STAT_W-1:0] search_status;
    logic [CNT_W-1:0]  bad_count;
    logic [CNT_W-1:0]  good_count;
    logic [IDX_W-1:0]  enabled_count;
    logic [IDX_W-1:0]  speed_ordinal;
    logic [IDX_W-1:0]  speed_index;
  } res_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } pick_t;

  // enable bits restricted to speeds that exist in the table
  function automatic logic [SLOTS-1:0] eff_mask(logic [MASK_W-1:0] m);
    logic [SLOTS-1:0] em;
    em = '0;
    for (int i = 0; i < TBL_SPEEDS; i++) em[i] = m[i];
    return em;
  endfunction

  function automatic logic [IDX_W-1:0] count_below(logic [SLOTS-1:0] em,
                                                   logic [IDX_W:0] lim);
    logic [IDX_W:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (em[i] && (i < lim)) n = n + 1'b1;
    end
    return n[IDX_W-1:0];
  endfunction

  // lowest enabled speed at or above lo
  function automatic pick_t first_from(logic [SLOTS-1:0] em, logic [IDX_W:0] lo);
    pick_t p;
    p = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (em[i] && (i >= lo)) begin
        p.hit = 1'b1;
        p.idx = IDX_W'(i);
      end
    end
    return p;
  endfunction

endpackage

@@ hdl/cbad_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_cfg_regs - configuration register file
// Holds the speed mask, preferred speed, limits and timeout.
// ----------------------------------------------------------------------------
module cbad_cfg_regs
  import cbad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_ENABLE_MASK: cfg_nxt.enable_mask     = wr_data[MASK_W-1:0];
        REG_PREFERRED:   cfg_nxt.preferred_speed = wr_data[IDX_W-1:0];
        REG_ERROR_LIMIT: cfg_nxt.error_limit     = wr_data[CNT_W-1:0];
        REG_HIT_LIMIT:   cfg_nxt.hit_limit       = wr_data[CNT_W-1:0];
        REG_TIMEOUT:     cfg_nxt.timeout_ticks   = wr_data[TICK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask     <= MASK_RST;
      cfg_r.preferred_speed <= PREF_RST;
      cfg_r.error_limit     <= ERR_LIM_RST;
      cfg_r.hit_limit       <= HIT_LIM_RST;
      cfg_r.timeout_ticks   <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/cbad_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbad_engine - search state and per-item update
// Holds the search state and computes the result and next state for the
// item in the input register; state commits when step is high.
// ----------------------------------------------------------------------------
module cbad_engine
  import cbad_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  step,
  output res_t  res
);

  logic              running_r,  running_nxt;
  logic [IDX_W-1:0]  index_r,    index_nxt;
  logic [IDX_W-1:0]  ordinal_r,  ordinal_nxt;
  logic [CNT_W-1:0]  good_r,     good_nxt;
  logic [CNT_W-1:0]  bad_r,      bad_nxt;
  logic              std_r,      std_nxt;
  logic              ext_r,      ext_nxt;
  logic [TICK_W-1:0] idle_r,     idle_nxt;
  logic [STAT_W-1:0] status_r,   status_nxt;

  logic [SLOTS-1:0]  em;
  pick_t             pick_first;
  pick_t             pick_above;
  pick_t             pick_next;
  logic              pref_on;
  logic              do_advance;
  logic              apply;
  logic              rreset;
  logic              restore;

  assign em         = eff_mask(cfg.enable_mask);
  assign pick_first = first_from(em, '0);
  assign pick_above = first_from(em, {1'b0, index_r} + 1'b1);
  assign pick_next  = pick_above.hit ? pick_above : pick_first;
  assign pref_on    = em[cfg.preferred_speed];

  always_comb begin
    running_nxt = running_r;
    index_nxt   = index_r;
    ordinal_nxt = ordinal_r;
    good_nxt    = good_r;
    bad_nxt     = bad_r;
    std_nxt     = std_r;
    ext_nxt     = ext_r;
    idle_nxt    = idle_r;
    status_nxt  = status_r;
    do_advance  = 1'b0;
    apply       = 1'b0;
    rreset      = 1'b0;
    restore     = 1'b0;

    if (item.operation == OP_START) begin
      restore  = running_r;
      good_nxt = '0;
      bad_nxt  = '0;
      std_nxt  = 1'b0;
      ext_nxt  = 1'b0;
      idle_nxt = '0;
      if (pref_on || pick_first.hit) begin
        running_nxt = 1'b1;
        index_nxt   = pref_on ? cfg.preferred_speed : pick_first.idx;
        ordinal_nxt = count_below(em, {1'b0, index_nxt});
        status_nxt  = ST_SEARCH;
        apply       = 1'b1;
      end else begin
        running_nxt = 1'b0;
        index_nxt   = '0;
        ordinal_nxt = '0;
        status_nxt  = ST_NONE;
      end
    end else if (running_r) begin
      case (item.operation)
        OP_FRAME: begin
          idle_nxt = '0;
          if (item.frame_error) begin
            if (bad_r != CNT_MAX) bad_nxt = bad_r + 1'b1;
          end else begin
            if (good_r != CNT_MAX) good_nxt = good_r + 1'b1;
            if (item.frame_extended) ext_nxt = 1'b1;
            else                     std_nxt = 1'b1;
          end
          if (bad_nxt >= cfg.error_limit) begin
            do_advance = 1'b1;
          end else if (good_nxt >= cfg.hit_limit) begin
            running_nxt = 1'b0;
            status_nxt  = ST_FOUND;
            restore     = 1'b1;
          end
        end
        OP_TICK: begin
          if (idle_r != TICK_MAX) idle_nxt = idle_r + 1'b1;
          if (idle_nxt >= cfg.timeout_ticks) do_advance = 1'b1;
        end
        OP_STATUS: begin
          idle_nxt = '0;
          if (!item.device_open) begin
            running_nxt = 1'b0;
            status_nxt  = ST_CLOSED;
            restore     = 1'b1;
          end else if (item.bus_off) begin
            rreset = 1'b1;
          end
        end
        OP_STOP: begin
          running_nxt = 1'b0;
          status_nxt  = ST_IDLE;
          restore     = 1'b1;
        end
        default: begin
          running_nxt = running_r;
        end
      endcase

      if (do_advance) begin
        good_nxt = '0;
        bad_nxt  = '0;
        std_nxt  = 1'b0;
        ext_nxt  = 1'b0;
        idle_nxt = '0;
        if (pick_next.hit) begin
          index_nxt   = pick_next.idx;
          ordinal_nxt = count_below(em, {1'b0, pick_next.idx});
          apply       = 1'b1;
        end else begin
          index_nxt   = '0;
          ordinal_nxt = '0;
          running_nxt = 1'b0;
          status_nxt  = ST_NONE;
          restore     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      index_r   <= '0;
      ordinal_r <= '0;
      good_r    <= '0;
      bad_r     <= '0;
      std_r     <= 1'b0;
      ext_r     <= 1'b0;
      idle_r    <= '0;
      status_r  <= ST_IDLE;
    end else if (step) begin
      running_r <= running_nxt;
      index_r   <= index_nxt;
      ordinal_r <= ordinal_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
      std_r     <= std_nxt;
      ext_r     <= ext_nxt;
      idle_r    <= idle_nxt;
      status_r  <= status_nxt;
    end
  end

  always_comb begin
    res.speed_index    = index_nxt;
    res.speed_ordinal  = ordinal_nxt;
    res.enabled_count  = count_below(em, (IDX_W + 1)'(SLOTS));
    res.good_count     = good_nxt;
    res.bad_count      = bad_nxt;
    res.search_status  = status_nxt;
    res.saw_standard   = std_nxt;
    res.saw_extended   = ext_nxt;
    res.apply_speed    = apply;
    res.request_reset  = rreset;
    res.restore_normal = restore;
  end

endmodule

@@ hdl/can_bitrate_autodetect_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_bitrate_autodetect_core - CAN bit-rate search controller
// Walks a table of bit rates in listen-only mode, counting good and error
// frames and idle ticks, and reports the speed once enough frames pass.
//
//   channel | dir | signals                          | transfer when
//   in      | in  | in_tvalid/in_tready/in_tdata/..  | in_tvalid & in_tready
//   out     | out | out_tvalid/out_tready/out_tdata  | out_tvalid & out_tready
//   cfg     | in  | cfg_valid/cfg_ready/index/data   | cfg_valid & cfg_ready
//
// One item per cycle sustained unless the output stalls; each item passes
// the input register, then the result register, before its result shows.
// rst_n is synchronous; it clears the search state and loads register
// defaults. A stalled result holds while one more item waits in the
// input register; cfg_ready is always high.
// ----------------------------------------------------------------------------
module can_bitrate_autodetect_core
  import cbad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // frame_error, frame_extended,
                                            // device_open, bus_off, 4'b0
  input  logic [OP_W-1:0]       in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // speed_index, speed_ordinal,
                                            // enabled_count, good_count,
                                            // bad_count, search_status,
                                            // saw_standard, saw_extended,
                                            // apply_speed, request_reset,
                                            // restore_normal, 4'b0
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t item_r;
  res_t  res;
  res_t  res_r;
  logic  in_valid_r;
  logic  out_valid_r;
  logic  out_free;
  logic  step;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || step;

  cbad_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cbad_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .step  (step),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.operation      <= in_tuser;
      item_r.frame_error    <= in_tdata[0];
      item_r.frame_extended <= in_tdata[1];
      item_r.device_open    <= in_tdata[2];
      item_r.bus_off        <= in_tdata[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r};

  // ---- assertions ----
  a_apply_searching: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.apply_speed) |-> (res_r.search_status == ST_SEARCH))
    else $error("apply_speed without an active search");

  a_restore_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.restore_normal && !res_r.apply_speed)
      |-> (res_r.search_status != ST_SEARCH))
    else $error("restore_normal while search still active");

  a_reset_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.request_reset)
      |-> (!res_r.apply_speed && !res_r.restore_normal
           && res_r.search_status == ST_SEARCH))
    else $error("request_reset combined with another pulse");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.speed_index < IDX_W'(TBL_SPEEDS)
                     || res_r.speed_index == '0))
    else $error("speed_index outside the table");

  a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("result lost after engine step");

endmodule
